### rtl/rbgs_pkg.sv
// ----------------------------------------------------------------------------
// rbgs_pkg: shared constants for the red-black Gauss-Seidel smoother
// Request codes, slot codes, widths and arithmetic limits.
// ----------------------------------------------------------------------------
`default_nettype none
package rbgs_pkg;
  localparam int MaxSide   = 64;
  localparam int Cells     = MaxSide * MaxSide;
  localparam int Taps      = 9;
  localparam int VW        = 32;
  localparam int FracBits  = 16;
  localparam int IdxW      = 12;
  localparam int SideW     = 7;
  localparam int AccW      = 128;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [3:0] SLOT_RHS = 4'd9;
  localparam logic [3:0] SLOT_SOL = 4'd10;

  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_SWEEPS = 2'd2;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;
endpackage
`default_nettype wire

### rtl/rbgs_div.sv
// ----------------------------------------------------------------------------
// rbgs_div: restoring divider, one quotient bit per cycle
// Divides a 128-bit magnitude by a 32-bit magnitude, then saturates to the
// signed 32-bit range with the requested sign.
// ----------------------------------------------------------------------------
`default_nettype none
module rbgs_div
  import rbgs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_ctl_t         ctl,
  input  wire logic [AccW-1:0]  num,
  input  wire logic [VW-1:0]    den,
  output logic                  done,
  output logic [VW-1:0]         quot
);
  logic [AccW-1:0] n;
  logic [AccW-1:0] q;
  logic [VW:0]     rem;
  logic [VW-1:0]   dm;
  logic [7:0]      cnt;
  logic            neg;
  logic            busy;
  logic [VW:0]     trial;
  logic [VW:0]     shifted;

  always_comb begin
    shifted = {rem[VW-1:0], n[AccW-1]};
    trial   = shifted - {1'b0, dm};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= 8'd0;
        n    <= num;
        dm   <= den;
        rem  <= '0;
        q    <= '0;
        neg  <= ctl.neg;
      end else if (busy) begin
        n <= {n[AccW-2:0], 1'b0};
        if (!trial[VW]) begin
          rem <= trial;
          q   <= {q[AccW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[AccW-2:0], 1'b0};
        end
        cnt <= cnt + 8'd1;
        if (cnt == 8'(AccW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate
  always_comb begin
    if (neg) begin
      if (q[AccW-1:VW-1] != '0 && q[AccW-1:0] != {{(AccW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}})
        quot = {1'b1, {(VW-1){1'b0}}};
      else
        quot = ~q[VW-1:0] + 1'b1;
    end else begin
      if (q[AccW-1:VW-1] != '0) quot = {1'b0, {(VW-1){1'b1}}};
      else quot = q[VW-1:0];
    end
  end
endmodule
`default_nettype wire

### rtl/red_black_gauss_seidel_smoother.sv
// ----------------------------------------------------------------------------
// red_black_gauss_seidel_smoother: nine-point red-black relaxation engine
//
//  channel | direction | contents
//  s_*     | in        | tuser=req_type, tdata={value,slot,cell_index}
//  m_*     | out       | tuser=done_kind, tdata=read_value
//  APB     | in        | grid_rows @0, grid_cols @4, sweep_count @8
//
// With the receiver ready a write goes from IDLE through OUT back to IDLE, and a
// read also passes through READ for the registered solution read.
// In a run a relaxed cell fetches its centre and rhs, then takes each of eight
// neighbour taps through FETCH, MUL and ACC, using one shared 32x32 multiplier
// into a 128-bit accumulator, then waits on a 128-step restoring divider; a
// cell of the other colour, or one with a zero centre, is skipped.
// Reset clears control only; stores are undefined until written.
// s_tready is low while a request is in progress or a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module red_black_gauss_seidel_smoother
  import rbgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // cell_index[11:0], slot[15:12], value[47:16]
  input  wire logic [1:0]  s_tuser,  // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // read_value[31:0]
  output logic [1:0]       m_tuser,  // done_kind[1:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_CELL  = 4'd3;
  localparam logic [3:0] ST_FETCH = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_ACC   = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_WAIT  = 4'd8;
  localparam logic [3:0] ST_NEXT  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // stores
  logic [VW-1:0] coef_mem [Cells*Taps];
  logic [VW-1:0] rhs_mem  [Cells];
  logic [VW-1:0] sol_mem  [Cells];
  logic [VW-1:0] coef_q, rhs_q, sol_q;

  logic [SideW-1:0] grid_rows, grid_cols;
  logic [7:0]       sweep_count;
  logic [3:0]       state;

  logic [IdxW-1:0]  idx_in;
  logic [3:0]       slot_in;
  logic [VW-1:0]    val_in;
  assign idx_in  = s_tdata[11:0];
  assign slot_in = s_tdata[15:12];
  assign val_in  = s_tdata[47:16];

  logic [SideW-1:0] rows, cols, ci, cj;
  logic [7:0]       sw;
  logic             colour;
  logic [3:0]       tap;
  logic [IdxW-1:0]  k;
  logic [VW-1:0]    centre;
  logic [AccW-1:0]  acc;
  logic [63:0]      prod;
  logic             prod_neg;
  logic [VW-1:0]    cmag, umag;

  logic             accept;
  assign accept   = s_tvalid && s_tready;
  // hold the input off until the previous result has been taken
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign pready   = 1'b1;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows   <= 7'd64;
      grid_cols   <= 7'd64;
      sweep_count <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ROWS:   grid_rows   <= pwdata[6:0];
        REG_COLS:   grid_cols   <= pwdata[6:0];
        REG_SWEEPS: sweep_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:   prdata = {25'd0, grid_rows};
      REG_COLS:   prdata = {25'd0, grid_cols};
      REG_SWEEPS: prdata = {24'd0, sweep_count};
      default:    prdata = '0;
    endcase
  end

  // neighbour address for current tap
  logic signed [2:0] di, dj;
  always_comb begin
    case (tap)
      4'd1:    begin di = 3'sd1;  dj = 3'sd0;  end
      4'd2:    begin di = -3'sd1; dj = 3'sd0;  end
      4'd3:    begin di = 3'sd0;  dj = 3'sd1;  end
      4'd4:    begin di = 3'sd0;  dj = -3'sd1; end
      4'd5:    begin di = 3'sd1;  dj = 3'sd1;  end
      4'd6:    begin di = -3'sd1; dj = 3'sd1;  end
      4'd7:    begin di = 3'sd1;  dj = -3'sd1; end
      4'd8:    begin di = -3'sd1; dj = -3'sd1; end
      default: begin di = 3'sd0;  dj = 3'sd0;  end
    endcase
  end
  logic [SideW-1:0] ni, nj;
  logic [IdxW-1:0]  nk, ck;
  assign ni = ci + SideW'(di);
  assign nj = cj + SideW'(dj);
  assign nk = IdxW'(ni) * IdxW'(cols) + IdxW'(nj);
  assign ck = IdxW'(ci) * IdxW'(cols) + IdxW'(cj);

  // single read address for each store
  logic [15:0]     coef_ra;
  logic [IdxW-1:0] sol_ra;
  assign coef_ra = 16'(k) * 16'(Taps) + 16'(tap);
  assign sol_ra  = (state == ST_IDLE) ? idx_in : nk;

  div_ctl_t       dctl;
  logic           ddone;
  logic [VW-1:0]  dq;

  rbgs_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(acc[AccW-1] ? -acc : acc),
    .den(centre[VW-1] ? -centre : centre), .done(ddone), .quot(dq)
  );
  assign dctl.start = (state == ST_DIV);
  assign dctl.neg   = acc[AccW-1] ^ centre[VW-1];

  // memory ports: writes from stream or from the divider result
  logic sol_we;
  logic [IdxW-1:0] sol_wa;
  logic [VW-1:0]   sol_wd;
  always_comb begin
    sol_we = 1'b0;
    sol_wa = idx_in;
    sol_wd = val_in;
    if (accept && s_tuser == REQ_WRITE && slot_in == SLOT_SOL) sol_we = 1'b1;
    if (state == ST_WAIT && ddone) begin
      sol_we = 1'b1;
      sol_wa = k;
      sol_wd = dq;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == REQ_WRITE && slot_in < 4'(Taps))
      coef_mem[16'(idx_in) * 16'(Taps) + 16'(slot_in)] <= val_in;
    if (accept && s_tuser == REQ_WRITE && slot_in == SLOT_RHS)
      rhs_mem[idx_in] <= val_in;
    if (sol_we) sol_mem[sol_wa] <= sol_wd;
    coef_q <= coef_mem[coef_ra];
    rhs_q  <= rhs_mem[k];
    sol_q  <= sol_mem[sol_ra];
  end

  assign cmag = coef_q[VW-1] ? -coef_q : coef_q;
  assign umag = sol_q[VW-1] ? -sol_q : sol_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (accept) begin
          m_tdata <= '0;
          m_tuser <= (s_tuser == REQ_RUN || s_tuser == REQ_READ) ? s_tuser : REQ_WRITE;
          if (s_tuser == REQ_READ) state <= ST_READ;
          else if (s_tuser == REQ_RUN) begin
            rows <= (grid_rows > 7'(MaxSide)) ? 7'(MaxSide) : grid_rows;
            cols <= (grid_cols > 7'(MaxSide)) ? 7'(MaxSide) : grid_cols;
            sw <= sweep_count;
            colour <= 1'b0;
            ci <= 7'd1;
            cj <= 7'd1;
            state <= ST_CELL;
            if (grid_rows < 7'd3 || grid_cols < 7'd3 || sweep_count == 8'd0)
              state <= ST_OUT;
          end else state <= ST_OUT;
        end
        // take the solution word registered at the accepting edge
        ST_READ: begin
          m_tdata <= sol_q;
          state <= ST_OUT;
        end
        ST_CELL: begin
          k <= ck;
          tap <= 4'd0;
          if (ci[0] ^ cj[0] ^ colour) state <= ST_NEXT;
          else state <= ST_FETCH;
        end
        ST_FETCH: state <= ST_MUL; // registered reads of tap data
        ST_MUL: begin
          if (tap == 4'd0) begin
            centre <= coef_q;
            acc <= {{(AccW-VW-FracBits){rhs_q[VW-1]}}, rhs_q, {FracBits{1'b0}}};
            if (coef_q == '0) state <= ST_NEXT;
            else begin
              tap <= 4'd1;
              state <= ST_FETCH;
            end
          end else begin
            prod <= cmag * umag;
            prod_neg <= (coef_q[VW-1] == sol_q[VW-1]);
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc <= prod_neg ? acc - AccW'(prod) : acc + AccW'(prod);
          if (tap == 4'(Taps - 1)) state <= ST_DIV;
          else begin
            tap <= tap + 4'd1;
            state <= ST_FETCH;
          end
        end
        ST_DIV:  state <= ST_WAIT;
        ST_WAIT: if (ddone) state <= ST_NEXT;
        ST_NEXT: begin
          state <= ST_CELL;
          if (cj + 7'd2 < cols) cj <= cj + 7'd1;
          else begin
            cj <= 7'd1;
            if (ci + 7'd2 < rows) ci <= ci + 7'd1;
            else begin
              ci <= 7'd1;
              colour <= ~colour;
              if (colour) begin
                sw <= sw - 8'd1;
                if (sw == 8'd1) state <= ST_OUT;
              end
            end
          end
        end
        ST_OUT: if (!m_tvalid) begin
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/rbgs_checker.sv
// ----------------------------------------------------------------------------
// rbgs_checker: port-level checks for the smoother
// Watches the stream handshakes and result data only.
// ----------------------------------------------------------------------------
`default_nettype none
module rbgs_checker
  import rbgs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [1:0]  m_tuser,
  input wire logic [31:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("took a second request while busy");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != REQ_READ |-> m_tdata == '0)
    else $error("non-read result carries data");
  a_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("ready while a result waits");
endmodule

bind red_black_gauss_seidel_smoother rbgs_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
);
`default_nettype wire
